// ===== src/spsc_pkg.sv =====
// ----------------------------------------------------------------------------
// spsc_pkg: shared types and constants for the stereo preamp chain
// Register indexes, reset values, the coefficient bundle and the rounding
// and saturation helpers used by the lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spsc_pkg;

	// default parameter values
	localparam int HP_IN_ALPHA_DEF  = 31221;
	localparam int HP_OUT_ALPHA_DEF = 4823;
	localparam int SAMPLE_BITS_DEF  = 24;

	// Q2.24 unity and shaper gain (0.1768)
	localparam longint COEF_ONE = 64'sd16777216;
	localparam logic signed [26:0] SHAPE_K = 27'sd2966212;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_IN_TRIM  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_PAD  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LP1_GAIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LP1_FB1  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LP1_FB2  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LP2_GAIN = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LP2_FB1  = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LP2_FB2  = 4'd7;

	// reset values
	localparam logic [22:0]        IN_TRIM_RST  = 23'd65536;
	localparam logic [16:0]        OUT_PAD_RST  = 17'd65536;
	localparam logic signed [25:0] LP1_GAIN_RST = 26'sd10984396;
	localparam logic signed [25:0] LP1_FB1_RST  = 26'sd21010611;
	localparam logic signed [25:0] LP1_FB2_RST  = 26'sd6149655;
	localparam logic signed [25:0] LP2_GAIN_RST = 26'sd13707975;
	localparam logic signed [25:0] LP2_FB1_RST  = 26'sd26220104;
	localparam logic signed [25:0] LP2_FB2_RST  = 26'sd11834128;

	// coefficient bundle handed to each lane
	typedef struct packed {
		logic [22:0]        in_trim;
		logic [16:0]        out_pad;
		logic signed [25:0] lp1_gain;
		logic signed [25:0] lp1_fb1;
		logic signed [25:0] lp1_fb2;
		logic signed [25:0] lp2_gain;
		logic signed [25:0] lp2_fb1;
		logic signed [25:0] lp2_fb2;
	} coef_t;

	// add half of the last kept unit, then floor shift
	function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
		input int unsigned s);
		logic signed [63:0] half;
		half = (64'sd1 <<< s) >>> 1;
		return (v + half) >>> s;
	endfunction

	// saturate to Q9.23
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/spsc_lane.sv =====
// ----------------------------------------------------------------------------
// spsc_lane: one channel of the preamp chain
// A step sequencer drives one shared multiply-accumulate unit through the
// highpass, trim, lowpass, shaper, lowpass, highpass and pad stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spsc_lane import spsc_pkg::*; #(
	parameter int HP_IN_ALPHA  = HP_IN_ALPHA_DEF,
	parameter int HP_OUT_ALPHA = HP_OUT_ALPHA_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire                          hold,
	input  wire  [SAMPLE_BITS-1:0]       din,
	input  coef_t                        coef,
	output logic [SAMPLE_BITS-1:0]       dout,
	output logic                         done
);

	localparam int UP = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
	localparam int DN = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;

	localparam logic signed [26:0] HPI_KEEP = 27'(COEF_ONE - HP_IN_ALPHA);
	localparam logic signed [26:0] HPI_MIX  = 27'(HP_IN_ALPHA);
	localparam logic signed [26:0] HPO_KEEP = 27'(COEF_ONE - HP_OUT_ALPHA);
	localparam logic signed [26:0] HPO_MIX  = 27'(HP_OUT_ALPHA);

	localparam logic signed [63:0] SMP_HI = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
	localparam logic signed [63:0] SMP_LO = -SMP_HI - 64'sd1;

	// sequencer steps
	localparam logic [4:0] ST_HPI_M0 = 5'd0;
	localparam logic [4:0] ST_HPI_M1 = 5'd1;
	localparam logic [4:0] ST_HPI_F  = 5'd2;
	localparam logic [4:0] ST_TRM_M  = 5'd3;
	localparam logic [4:0] ST_TRM_F  = 5'd4;
	localparam logic [4:0] ST_LP1_M0 = 5'd5;
	localparam logic [4:0] ST_LP1_M1 = 5'd6;
	localparam logic [4:0] ST_LP1_M2 = 5'd7;
	localparam logic [4:0] ST_LP1_M3 = 5'd8;
	localparam logic [4:0] ST_LP1_M4 = 5'd9;
	localparam logic [4:0] ST_LP1_F  = 5'd10;
	localparam logic [4:0] ST_SH_M0  = 5'd11;
	localparam logic [4:0] ST_SH_F0  = 5'd12;
	localparam logic [4:0] ST_SH_M1  = 5'd13;
	localparam logic [4:0] ST_SH_F1  = 5'd14;
	localparam logic [4:0] ST_SH_M2  = 5'd15;
	localparam logic [4:0] ST_SH_F2  = 5'd16;
	localparam logic [4:0] ST_SH_M3  = 5'd17;
	localparam logic [4:0] ST_SH_F3  = 5'd18;
	localparam logic [4:0] ST_LP2_M0 = 5'd19;
	localparam logic [4:0] ST_LP2_M1 = 5'd20;
	localparam logic [4:0] ST_LP2_M2 = 5'd21;
	localparam logic [4:0] ST_LP2_M3 = 5'd22;
	localparam logic [4:0] ST_LP2_M4 = 5'd23;
	localparam logic [4:0] ST_LP2_F  = 5'd24;
	localparam logic [4:0] ST_HPO_M0 = 5'd25;
	localparam logic [4:0] ST_HPO_M1 = 5'd26;
	localparam logic [4:0] ST_HPO_F  = 5'd27;
	localparam logic [4:0] ST_PAD_M  = 5'd28;
	localparam logic [4:0] ST_PAD_F  = 5'd29;

	logic              run_q;
	logic [4:0]        step_q;
	logic signed [31:0] x_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] t_q;
	logic signed [24:0] sx_q;
	logic signed [31:0] hpi_q, hpo_q;
	logic signed [31:0] lp1_h_q [4];
	logic signed [31:0] lp2_h_q [4];

	logic signed [31:0] a_op;
	logic signed [26:0] b_op;
	logic               mac, clr;
	logic signed [58:0] prod;
	logic signed [63:0] acc_nxt;
	logic signed [24:0] clamp_x;
	logic signed [63:0] din_ext;
	logic signed [31:0] din_q23;
	logic signed [63:0] y_r24, y_r23, y_r16;
	logic signed [31:0] pad_y;
	logic signed [63:0] out_v;

	// shaper input clamp to +-1
	always_comb begin
		if (x_q > 32'sd8388608)
			clamp_x = 25'sd8388608;
		else if (x_q < -32'sd8388608)
			clamp_x = -25'sd8388608;
		else
			clamp_x = x_q[24:0];
	end

	// operand select for the shared multiplier
	always_comb begin
		a_op = x_q;
		b_op = '0;
		mac  = 1'b0;
		clr  = 1'b0;
		case (step_q)
			ST_HPI_M0: begin a_op = hpi_q; b_op = HPI_KEEP; mac = 1'b1; clr = 1'b1; end
			ST_HPI_M1: begin a_op = x_q; b_op = HPI_MIX; mac = 1'b1; end
			ST_TRM_M: begin
				a_op = x_q; b_op = 27'($signed({1'b0, coef.in_trim})); mac = 1'b1; clr = 1'b1;
			end
			ST_LP1_M0: begin
				a_op = x_q; b_op = 27'(coef.lp1_gain); mac = 1'b1; clr = 1'b1;
			end
			ST_LP1_M1: begin a_op = lp1_h_q[0]; b_op = {coef.lp1_gain, 1'b0}; mac = 1'b1; end
			ST_LP1_M2: begin a_op = lp1_h_q[1]; b_op = 27'(coef.lp1_gain); mac = 1'b1; end
			ST_LP1_M3: begin a_op = lp1_h_q[2]; b_op = -27'(coef.lp1_fb1); mac = 1'b1; end
			ST_LP1_M4: begin a_op = lp1_h_q[3]; b_op = -27'(coef.lp1_fb2); mac = 1'b1; end
			ST_SH_M0: begin
				a_op = 32'(clamp_x); b_op = 27'(clamp_x); mac = 1'b1; clr = 1'b1;
			end
			ST_SH_M1: begin a_op = t_q; b_op = t_q[26:0]; mac = 1'b1; clr = 1'b1; end
			ST_SH_M2: begin a_op = t_q; b_op = 27'(sx_q); mac = 1'b1; clr = 1'b1; end
			ST_SH_M3: begin a_op = t_q; b_op = SHAPE_K; mac = 1'b1; clr = 1'b1; end
			ST_LP2_M0: begin
				a_op = x_q; b_op = 27'(coef.lp2_gain); mac = 1'b1; clr = 1'b1;
			end
			ST_LP2_M1: begin a_op = lp2_h_q[0]; b_op = {coef.lp2_gain, 1'b0}; mac = 1'b1; end
			ST_LP2_M2: begin a_op = lp2_h_q[1]; b_op = 27'(coef.lp2_gain); mac = 1'b1; end
			ST_LP2_M3: begin a_op = lp2_h_q[2]; b_op = -27'(coef.lp2_fb1); mac = 1'b1; end
			ST_LP2_M4: begin a_op = lp2_h_q[3]; b_op = -27'(coef.lp2_fb2); mac = 1'b1; end
			ST_HPO_M0: begin a_op = hpo_q; b_op = HPO_KEEP; mac = 1'b1; clr = 1'b1; end
			ST_HPO_M1: begin a_op = x_q; b_op = HPO_MIX; mac = 1'b1; end
			ST_PAD_M: begin
				a_op = x_q; b_op = 27'($signed({1'b0, coef.out_pad})); mac = 1'b1; clr = 1'b1;
			end
			default: begin
				a_op = x_q;
				b_op = '0;
			end
		endcase
	end

	assign prod    = a_op * b_op;
	assign acc_nxt = (clr ? 64'sd0 : acc_q) + 64'(prod);

	// rounded views of the accumulator
	assign y_r24 = rnd_sh(acc_q, 24);
	assign y_r23 = rnd_sh(acc_q, 23);
	assign y_r16 = rnd_sh(acc_q, 16);

	// input sample to Q9.23
	assign din_ext = 64'($signed(din));
	assign din_q23 = 32'((din_ext <<< UP) >>> DN);

	// output pad result back to the sample format
	assign pad_y = sat32(y_r16);
	always_comb begin
		out_v = rnd_sh(64'(pad_y) <<< DN, UP);
		if (out_v > SMP_HI)
			dout = SMP_HI[SAMPLE_BITS-1:0];
		else if (out_v < SMP_LO)
			dout = SMP_LO[SAMPLE_BITS-1:0];
		else
			dout = out_v[SAMPLE_BITS-1:0];
	end

	assign done = run_q && (step_q == ST_PAD_F) && !hold;

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			step_q <= ST_HPI_M0;
		end else if (start && !run_q) begin
			run_q  <= 1'b1;
			step_q <= ST_HPI_M0;
		end else if (run_q) begin
			if (step_q == ST_PAD_F) begin
				if (!hold) begin
					run_q  <= 1'b0;
					step_q <= ST_HPI_M0;
				end
			end else begin
				step_q <= step_q + 5'd1;
			end
		end
	end

	// filter state, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hpi_q <= '0;
			hpo_q <= '0;
			for (int i = 0; i < 4; i++) begin
				lp1_h_q[i] <= '0;
				lp2_h_q[i] <= '0;
			end
		end else if (run_q) begin
			case (step_q)
				ST_HPI_F: hpi_q <= sat32(y_r24);
				ST_LP1_F: begin
					lp1_h_q[1] <= lp1_h_q[0];
					lp1_h_q[0] <= x_q;
					lp1_h_q[3] <= lp1_h_q[2];
					lp1_h_q[2] <= sat32(y_r24);
				end
				ST_LP2_F: begin
					lp2_h_q[1] <= lp2_h_q[0];
					lp2_h_q[0] <= x_q;
					lp2_h_q[3] <= lp2_h_q[2];
					lp2_h_q[2] <= sat32(y_r24);
				end
				ST_HPO_F: hpo_q <= sat32(y_r24);
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (start && !run_q) begin
			x_q <= din_q23;
		end else if (run_q) begin
			if (mac)
				acc_q <= acc_nxt;
			case (step_q)
				ST_HPI_F: x_q <= sat32(64'(x_q) - 64'(sat32(y_r24)));
				ST_TRM_F: x_q <= sat32(y_r16);
				ST_LP1_F: x_q <= sat32(y_r24);
				ST_SH_M0: sx_q <= clamp_x;
				ST_SH_F0: t_q <= y_r23[31:0];
				ST_SH_F1: t_q <= y_r23[31:0];
				ST_SH_F2: t_q <= y_r23[31:0];
				ST_SH_F3: x_q <= sat32(64'(sx_q) - y_r24);
				ST_LP2_F: x_q <= sat32(y_r24);
				ST_HPO_F: x_q <= sat32(64'(x_q) - 64'(sat32(y_r24)));
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// a finished item only leaves from the last step of a running lane
	a_done_running: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> run_q && step_q == ST_PAD_F)
		else $error("lane done outside last step");

	// the step counter advances by one while running and not at the end
	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && step_q != ST_PAD_F |=> step_q == $past(step_q) + 5'd1)
		else $error("lane step skipped");

	// a held lane keeps its result step
	a_hold_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		run_q && step_q == ST_PAD_F && hold |=> run_q && step_q == ST_PAD_F)
		else $error("lane left result step while held");
`endif

endmodule

`default_nettype wire

// ===== src/stereo_preamp_saturation_chain.sv =====
// ----------------------------------------------------------------------------
// stereo_preamp_saturation_chain: stereo preamp with soft saturation
// Two channel lanes run in lockstep; the result register merges them into
// one output frame. Coefficient registers are written over a side channel.
// ----------------------------------------------------------------------------
//  channel   | signals                          | carries
//  s_axis    | tvalid tready tdata              | left_in, right_in
//  m_axis    | tvalid tready tdata              | left_out, right_out
//  cfg       | valid ready index data           | register index, value
//
//  From accept to result, each lane runs 20 multiply-accumulate steps and
//  10 rounding steps on its one multiplier. The input reopens with the
//  result; a new frame is not taken while the last one is still in a lane.
//  A new frame is accepted once the lanes have moved their result into the
//  output register, even while that register waits on m_axis_tready.
//  Reset clears all filter state and loads the default coefficients.
//  Config writes are always ready and take effect at once; write them only
//  while no frame is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stereo_preamp_saturation_chain import spsc_pkg::*; #(
	parameter int HP_IN_ALPHA  = HP_IN_ALPHA_DEF,
	parameter int HP_OUT_ALPHA = HP_OUT_ALPHA_DEF,
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
	localparam int TDW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire  [TDW-1:0]         s_axis_tdata,   // left_in, right_in, zero pad
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	output logic [TDW-1:0]         m_axis_tdata,   // left_out, right_out, zero pad
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [CFG_IDX_W-1:0]   cfg_index,
	input  wire  [CFG_DATA_W-1:0]  cfg_data
);

	coef_t coef_q;
	logic  busy_q;
	logic  out_vld_q;
	logic  [SAMPLE_BITS-1:0] left_q, right_q;
	logic  [SAMPLE_BITS-1:0] left_y, right_y;
	logic  done_l, done_r;
	logic  in_beat, out_beat, hold;

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_beat = m_axis_tvalid && m_axis_tready;
	assign hold     = out_vld_q && !m_axis_tready;

	assign s_axis_tready = !busy_q;
	assign cfg_ready     = 1'b1;

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.in_trim  <= IN_TRIM_RST;
			coef_q.out_pad  <= OUT_PAD_RST;
			coef_q.lp1_gain <= LP1_GAIN_RST;
			coef_q.lp1_fb1  <= LP1_FB1_RST;
			coef_q.lp1_fb2  <= LP1_FB2_RST;
			coef_q.lp2_gain <= LP2_GAIN_RST;
			coef_q.lp2_fb1  <= LP2_FB1_RST;
			coef_q.lp2_fb2  <= LP2_FB2_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IN_TRIM:  coef_q.in_trim  <= cfg_data[22:0];
				REG_OUT_PAD:  coef_q.out_pad  <= cfg_data[16:0];
				REG_LP1_GAIN: coef_q.lp1_gain <= cfg_data[25:0];
				REG_LP1_FB1:  coef_q.lp1_fb1  <= cfg_data[25:0];
				REG_LP1_FB2:  coef_q.lp1_fb2  <= cfg_data[25:0];
				REG_LP2_GAIN: coef_q.lp2_gain <= cfg_data[25:0];
				REG_LP2_FB1:  coef_q.lp2_fb1  <= cfg_data[25:0];
				REG_LP2_FB2:  coef_q.lp2_fb2  <= cfg_data[25:0];
				default: ;
			endcase
		end
	end

	// channel lanes
	spsc_lane #(
		.HP_IN_ALPHA (HP_IN_ALPHA),
		.HP_OUT_ALPHA(HP_OUT_ALPHA),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_l (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_beat),
		.hold  (hold),
		.din   (s_axis_tdata[SAMPLE_BITS-1:0]),
		.coef  (coef_q),
		.dout  (left_y),
		.done  (done_l)
	);

	spsc_lane #(
		.HP_IN_ALPHA (HP_IN_ALPHA),
		.HP_OUT_ALPHA(HP_OUT_ALPHA),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_r (
		.clk   (clk),
		.arst_n(arst_n),
		.start (in_beat),
		.hold  (hold),
		.din   (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
		.coef  (coef_q),
		.dout  (right_y),
		.done  (done_r)
	);

	// frame busy flag and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_beat)
				busy_q <= 1'b1;
			else if (done_l)
				busy_q <= 1'b0;
			if (done_l)
				out_vld_q <= 1'b1;
			else if (out_beat)
				out_vld_q <= 1'b0;
		end
	end

	// merged result register
	always_ff @(posedge clk) begin
		if (done_l) begin
			left_q  <= left_y;
			right_q <= right_y;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = TDW'({right_q, left_q});

`ifndef ASSERT_OFF
	// both lanes finish in the same cycle
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		done_l == done_r)
		else $error("lanes out of step");

	// an accepted frame keeps the input closed next cycle
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> busy_q && !s_axis_tready)
		else $error("input open after accept");

	// a lane result only appears for a frame in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_l |-> busy_q)
		else $error("result without frame");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done_l |-> !out_vld_q || m_axis_tready)
		else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/spsc_checker.sv =====
// ----------------------------------------------------------------------------
// spsc_checker: frame predictor and scoreboard for the stereo preamp chain
// Watches the input, output and register channels, runs a bit-exact copy of
// both channel lanes for every accepted input beat and compares each output
// beat against the oldest predicted frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spsc_checker import spsc_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_axis_tvalid,
	input  wire                   s_axis_tready,
	input  wire  [47:0]           s_axis_tdata,   // left_in, right_in
	input  wire                   m_axis_tvalid,
	input  wire                   m_axis_tready,
	input  wire  [47:0]           m_axis_tdata,   // left_out, right_out
	input  wire                   cfg_valid,
	input  wire                   cfg_ready,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam longint HPI_A = HP_IN_ALPHA_DEF;
	localparam longint HPO_A = HP_OUT_ALPHA_DEF;

	// register copies
	logic [22:0] trim_q;
	logic [16:0] pad_q;
	longint      lp1_a0, lp1_b1, lp1_b2, lp2_a0, lp2_b1, lp2_b2;

	// per-channel filter state: x1, x2, y1, y2 for each lowpass
	logic signed [31:0] dc_in_lvl [2];
	logic signed [31:0] dc_out_lvl [2];
	logic signed [31:0] lp1_st [2][4];
	logic signed [31:0] lp2_st [2][4];

	logic [47:0] frames_due [$];

	// add half of the last kept unit, then floor shift
	function automatic longint round_sh(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(input longint v, input int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// one-pole DC blocker, outer selects the output-side stage
	function automatic longint dc_block(input int ch, input bit outer, input longint x);
		longint a, lvl;
		a   = outer ? HPO_A : HPI_A;
		lvl = outer ? dc_out_lvl[ch] : dc_in_lvl[ch];
		lvl = clip(round_sh(lvl * (COEF_ONE - a) + x * a, 24), 32);
		if (outer) dc_out_lvl[ch] = lvl[31:0];
		else dc_in_lvl[ch] = lvl[31:0];
		return clip(x - lvl, 32);
	endfunction

	// DF1 lowpass with numerator a0*(1,2,1)
	function automatic longint lowpass(input int ch, input bit second, input longint x);
		longint a0, b1, b2, acc, y;
		logic signed [31:0] h [4];
		if (second) begin
			a0 = lp2_a0;
			b1 = lp2_b1;
			b2 = lp2_b2;
			for (int k = 0; k < 4; k++) h[k] = lp2_st[ch][k];
		end else begin
			a0 = lp1_a0;
			b1 = lp1_b1;
			b2 = lp1_b2;
			for (int k = 0; k < 4; k++) h[k] = lp1_st[ch][k];
		end
		acc = a0 * x + 2 * a0 * longint'(h[0]) + a0 * longint'(h[1])
			- b1 * longint'(h[2]) - b2 * longint'(h[3]);
		y = clip(round_sh(acc, 24), 32);
		h[1] = h[0];
		h[0] = x[31:0];
		h[3] = h[2];
		h[2] = y[31:0];
		if (second) begin
			for (int k = 0; k < 4; k++) lp2_st[ch][k] = h[k];
		end else begin
			for (int k = 0; k < 4; k++) lp1_st[ch][k] = h[k];
		end
		return y;
	endfunction

	// clamp to +-1, then x - K*x^5
	function automatic longint soft_clip(input longint x);
		longint sq, q4, q5;
		if (x > 64'sd8388608) x = 64'sd8388608;
		if (x < -64'sd8388608) x = -64'sd8388608;
		sq = round_sh(x * x, 23);
		q4 = round_sh(sq * sq, 23);
		q5 = round_sh(q4 * x, 23);
		return x - round_sh(q5 * longint'(SHAPE_K), 24);
	endfunction

	function automatic logic [23:0] preamp_lane(input int ch, input logic [23:0] raw);
		longint x;
		x = longint'($signed(raw));
		x = dc_block(ch, 1'b0, x);
		x = clip(round_sh(x * longint'(trim_q), 16), 32);
		x = lowpass(ch, 1'b0, x);
		x = soft_clip(x);
		x = lowpass(ch, 1'b1, x);
		x = dc_block(ch, 1'b1, x);
		x = clip(round_sh(x * longint'(pad_q), 16), 32);
		x = clip(x, 24);
		return x[23:0];
	endfunction

	task automatic note_miss(input string what, input logic [23:0] want, input logic [23:0] got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch %s: expected %0d got %0d", what, $signed(want), $signed(got));
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [47:0] want;
		logic [23:0] l, r;
		if (!arst_n) begin
			trim_q = IN_TRIM_RST;
			pad_q  = OUT_PAD_RST;
			lp1_a0 = LP1_GAIN_RST; lp1_b1 = LP1_FB1_RST; lp1_b2 = LP1_FB2_RST;
			lp2_a0 = LP2_GAIN_RST; lp2_b1 = LP2_FB1_RST; lp2_b2 = LP2_FB2_RST;
			for (int c = 0; c < 2; c++) begin
				dc_in_lvl[c]  = '0;
				dc_out_lvl[c] = '0;
				for (int k = 0; k < 4; k++) begin
					lp1_st[c][k] = '0;
					lp2_st[c][k] = '0;
				end
			end
			frames_due.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// register write
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IN_TRIM:  trim_q = cfg_data[22:0];
					REG_OUT_PAD:  pad_q  = cfg_data[16:0];
					REG_LP1_GAIN: lp1_a0 = longint'($signed(cfg_data[25:0]));
					REG_LP1_FB1:  lp1_b1 = longint'($signed(cfg_data[25:0]));
					REG_LP1_FB2:  lp1_b2 = longint'($signed(cfg_data[25:0]));
					REG_LP2_GAIN: lp2_a0 = longint'($signed(cfg_data[25:0]));
					REG_LP2_FB1:  lp2_b1 = longint'($signed(cfg_data[25:0]));
					REG_LP2_FB2:  lp2_b2 = longint'($signed(cfg_data[25:0]));
					default: ;
				endcase
			end
			// output beat against the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				if (frames_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected output beat %h", m_axis_tdata);
				end else begin
					want = frames_due.pop_front();
					if (m_axis_tdata[23:0] !== want[23:0])
						note_miss("left_out", want[23:0], m_axis_tdata[23:0]);
					if (m_axis_tdata[47:24] !== want[47:24])
						note_miss("right_out", want[47:24], m_axis_tdata[47:24]);
				end
			end
			// input beat: predict the frame
			if (s_axis_tvalid && s_axis_tready) begin
				l = preamp_lane(0, s_axis_tdata[23:0]);
				r = preamp_lane(1, s_axis_tdata[47:24]);
				frames_due.push_back({r, l});
			end
			pending = frames_due.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the stereo preamp chain
// Walks the block through several register settings (defaults, extremes,
// zero gains, unstable filters, random values) with directed and random
// stereo frames, random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
	import spsc_pkg::*;

	localparam int LIMIT = 400000;
	localparam int DRAIN = 60;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [47:0]           s_axis_tdata;   // left_in, right_in
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [47:0]           m_axis_tdata;   // left_out, right_out
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int cycles;
	bit calm_tx, calm_rx;

	stereo_preamp_saturation_chain dut (.*);

	spsc_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// timeout
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver with random stalls
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = calm_rx ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// register write; valid stays high for back-to-back writes
	task automatic load_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_all(input logic [31:0] trim, input logic [31:0] pad,
		input logic [31:0] g1, input logic [31:0] f11, input logic [31:0] f12,
		input logic [31:0] g2, input logic [31:0] f21, input logic [31:0] f22);
		load_reg(REG_IN_TRIM, trim);
		load_reg(REG_OUT_PAD, pad);
		load_reg(REG_LP1_GAIN, g1);
		load_reg(REG_LP1_FB1, f11);
		load_reg(REG_LP1_FB2, f12);
		load_reg(REG_LP2_GAIN, g2);
		load_reg(REG_LP2_FB1, f21);
		load_reg(REG_LP2_FB2, f22);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one frame beat; valid stays high when the next gap is zero
	task automatic send_frame(input logic [23:0] l, input logic [23:0] r);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r, l};
		do @(posedge clk); while (!s_axis_tready);
		gap = calm_tx ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(0, 5))
			0, 1: return 24'($urandom);
			2:    return 24'($signed($urandom_range(0, 8000)) - 4000);
			3:    return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
			default: return 24'($signed($urandom_range(0, 2000000)) - 1000000);
		endcase
	endfunction

	task automatic random_run(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 25 == 0) begin
				calm_tx = ($urandom_range(0, 3) == 0);
				calm_rx = ($urandom_range(0, 3) == 0);
			end
			// hold off once until the chain is empty
			if (i == n / 2) drain;
			send_frame(pick_sample(), pick_sample());
		end
		drain;
	endtask

	initial begin
		logic [23:0] edge_vals [8];
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		calm_tx       = 1'b0;
		calm_rx       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames at reset settings
		edge_vals = '{24'h000000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF,
			24'h000001, 24'h555555, 24'hAAAAAA, 24'h400000};
		for (int i = 0; i < 8; i++)
			send_frame(edge_vals[i], edge_vals[7 - i]);
		for (int i = 0; i < 6; i++)
			send_frame(24'h7FFFFF, 24'h800000);
		drain;
		random_run(60);

		// trim and pad above range (masked), unstable filters at extremes
		load_all(32'hFFFFFFFF, 32'hFFFFFFFF, 32'h01FFFFFF, 32'h02000000, 32'h01FFFFFF,
			32'h01FFFFFF, 32'h02000000, 32'h01FFFFFF);
		for (int i = 0; i < 8; i++)
			send_frame(edge_vals[i], edge_vals[i]);
		random_run(60);

		// zero gains, most negative coefficients
		load_all(32'd0, 32'd0, 32'h02000000, 32'h02000000, 32'h02000000,
			32'h02000000, 32'h02000000, 32'h02000000);
		random_run(50);

		// full trim and pad, default filters, writes to unused indexes
		load_all(32'd6553600, 32'd65536, LP1_GAIN_RST, LP1_FB1_RST, LP1_FB2_RST,
			LP2_GAIN_RST, LP2_FB1_RST, LP2_FB2_RST);
		for (int k = 1; k <= 8; k++)
			load_reg(CFG_IDX_W'(REG_LP2_FB2 + k), $urandom);
		cfg_valid <= 1'b0;
		@(posedge clk);
		random_run(70);

		// fully random register values
		load_all($urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom);
		random_run(70);

		// defaults with random trim and pad
		load_all($urandom_range(0, 6553600), $urandom_range(0, 65536), LP1_GAIN_RST,
			LP1_FB1_RST, LP1_FB2_RST, LP2_GAIN_RST, LP2_FB1_RST, LP2_FB2_RST);
		random_run(120);

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
src/spsc_pkg.sv
src/spsc_lane.sv
src/stereo_preamp_saturation_chain.sv
tb/sv/spsc_checker.sv
tb/sv/tb_top.sv
